/* hw/rtl/unordered_pair_table_unit_assert.svh */
// Assertion macros for the unordered pair table.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef UNORDERED_PAIR_TABLE_UNIT_ASSERT_SVH
`define UNORDERED_PAIR_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define UPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/upt_pkg.sv */
// Package for the unordered pair table: sizes, function and status codes,
// slot entry type. No dependencies.
`default_nettype none

package upt_pkg;

  localparam int unsigned ENTRIES = 32;
  localparam int unsigned ID_BITS = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CNT_W   = 6;

  localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE_PAIR = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE_OBJ = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE_TAG = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DRAIN      = 3'd4;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND  = 3'd4;
  localparam logic [STAT_W-1:0] ST_DRAINED   = 3'd5;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd6;

  typedef struct packed {
    logic [ID_BITS-1:0] first;
    logic [ID_BITS-1:0] second;
    logic [FIELD_W-1:0] tag;
  } upt_entry_t;

endpackage

`default_nettype wire

/* hw/rtl/upt_if.sv */
// Handshake channels of the unordered pair table: request and result.
// Depends on upt_pkg.
`default_nettype none

interface upt_in_if;
  import upt_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [FIELD_W-1:0]  obj_a;
  logic [FIELD_W-1:0]  obj_b;
  logic [FIELD_W-1:0]  tag;
  modport source (output valid, func, obj_a, obj_b, tag, input ready);
  modport sink   (input valid, func, obj_a, obj_b, tag, output ready);
endinterface

interface upt_out_if;
  import upt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [FIELD_W-1:0]  pair_a;
  logic [FIELD_W-1:0]  pair_b;
  logic [CNT_W-1:0]    removed_count;
  logic                final_item;
  modport source (output valid, status, pair_a, pair_b, removed_count, final_item,
                  input ready);
  modport sink   (input valid, status, pair_a, pair_b, removed_count, final_item,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/unordered_pair_table_unit.sv */
// Unordered pair table: slot memory, valid flags, scan sequencer, result register.
// Depends on upt_pkg, upt_if.sv and unordered_pair_table_unit_assert.svh.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   func, obj_a, obj_b, tag
//   out_o    out  valid/ready   status, pair_a, pair_b, removed_count, final_item
//
// An item scans the slot memory one slot per cycle unless a full result register
// stalls it, and stops early when a pair, duplicate or tag match ends the scan.
// The registered read of the slot memory sets the pace.
// Drain emits one item per used slot; a full result register stalls the scan.
// Reset clears all valid flags at once; no clearing pass. Unused func codes are
// taken and give no result.
`default_nettype none
`include "unordered_pair_table_unit_assert.svh"

module unordered_pair_table_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  upt_in_if.sink      in_i,
  upt_out_if.source   out_o
);
  import upt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [ENTRIES-1:0] ONE_HOT0 = ENTRIES'(1);

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [FUNC_W-1:0]   func_q, func_d;
  logic [ID_BITS-1:0]  a_q, a_d, b_q, b_d;
  logic [FIELD_W-1:0]  tag_q, tag_d;
  logic                free_fnd_q, free_fnd_d;
  logic [IDX_W-1:0]    free_idx_q, free_idx_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                any_q, any_d;
  logic [ENTRIES-1:0]  valid_q, valid_d;

  upt_entry_t          mem_q [ENTRIES];
  upt_entry_t          rd_q;
  upt_entry_t          wr_ent;
  logic                mem_we;
  logic [IDX_W-1:0]    wr_idx;

  logic                ovld_q;
  logic [STAT_W-1:0]   ostat_q;
  logic [FIELD_W-1:0]  opa_q, opb_q;
  logic [CNT_W-1:0]    ocnt_q;
  logic                ofin_q;

  logic                emit;
  logic [STAT_W-1:0]   e_stat;
  logic [FIELD_W-1:0]  e_pa, e_pb;
  logic [CNT_W-1:0]    e_cnt;
  logic                e_fin;

  logic                out_free, cur_vld, last_slot, last_pair;
  logic                hit_pair, hit_obj, hit_tag, done;
  logic [CNT_W-1:0]    cnt_inc;

  assign out_free  = !ovld_q || out_o.ready;
  assign cur_vld   = valid_q[idx_q];
  assign last_slot = (idx_q == LAST_IDX);
  assign last_pair = ((valid_q & ~(ONE_HOT0 << idx_q)) == '0);
  assign hit_pair  = cur_vld && ((rd_q.first == a_q && rd_q.second == b_q) ||
                                 (rd_q.first == b_q && rd_q.second == a_q));
  assign hit_obj   = cur_vld && (rd_q.first == a_q || rd_q.second == a_q);
  assign hit_tag   = hit_obj && (rd_q.tag == tag_q);
  assign cnt_inc   = cnt_q + CNT_W'(hit_obj);

  assign wr_ent.first  = a_q;
  assign wr_ent.second = b_q;
  assign wr_ent.tag    = tag_q;
  assign wr_idx        = free_fnd_q ? free_idx_q : idx_q;

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    func_d     = func_q;
    a_d        = a_q;
    b_d        = b_q;
    tag_d      = tag_q;
    free_fnd_d = free_fnd_q;
    free_idx_d = free_idx_q;
    cnt_d      = cnt_q;
    any_d      = any_q;
    valid_d    = valid_q;
    mem_we     = 1'b0;
    emit       = 1'b0;
    e_stat     = ST_NOTFOUND;
    e_pa       = '0;
    e_pb       = '0;
    e_cnt      = '0;
    e_fin      = 1'b1;
    done       = 1'b0;
    case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (in_i.valid) begin
          func_d     = in_i.func;
          a_d        = ID_BITS'(in_i.obj_a);
          b_d        = ID_BITS'(in_i.obj_b);
          tag_d      = in_i.tag;
          free_fnd_d = 1'b0;
          free_idx_d = '0;
          cnt_d      = '0;
          any_d      = 1'b0;
          if (in_i.func <= FN_DRAIN) begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (out_free) begin
          case (func_q)
            FN_INSERT: begin
              if (hit_pair) begin
                emit   = 1'b1;
                e_stat = ST_DUPLICATE;
                done   = 1'b1;
              end else begin
                if (!cur_vld && !free_fnd_q) begin
                  free_fnd_d = 1'b1;
                  free_idx_d = idx_q;
                end
                if (last_slot) begin
                  emit = 1'b1;
                  done = 1'b1;
                  if (free_fnd_q || !cur_vld) begin
                    mem_we          = 1'b1;
                    valid_d[wr_idx] = 1'b1;
                    e_stat          = ST_INSERTED;
                  end else begin
                    e_stat = ST_FULL;
                  end
                end
              end
            end
            FN_REMOVE_PAIR, FN_REMOVE_TAG: begin
              if ((func_q == FN_REMOVE_PAIR) ? hit_pair : hit_tag) begin
                valid_d[idx_q] = 1'b0;
                emit           = 1'b1;
                e_stat         = ST_REMOVED;
                e_cnt          = CNT_W'(1);
                done           = 1'b1;
              end else if (last_slot) begin
                emit = 1'b1;
                done = 1'b1;
              end
            end
            FN_REMOVE_OBJ: begin
              if (hit_obj) begin
                valid_d[idx_q] = 1'b0;
                any_d          = 1'b1;
              end
              cnt_d = cnt_inc;
              if (last_slot) begin
                emit   = 1'b1;
                done   = 1'b1;
                e_cnt  = cnt_inc;
                e_stat = (any_q || hit_obj) ? ST_REMOVED : ST_NOTFOUND;
              end
            end
            FN_DRAIN: begin
              if (cur_vld) begin
                valid_d[idx_q] = 1'b0;
                any_d          = 1'b1;
                emit           = 1'b1;
                e_stat         = ST_DRAINED;
                e_pa           = FIELD_W'(rd_q.first);
                e_pb           = FIELD_W'(rd_q.second);
                e_cnt          = CNT_W'(1);
                e_fin          = last_pair;
                done           = last_pair || last_slot;
              end else if (last_slot) begin
                done = 1'b1;
                if (!any_q) begin
                  emit   = 1'b1;
                  e_stat = ST_EMPTY;
                end
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
          if (done) begin
            state_d = S_IDLE;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx] <= wr_ent;
    end
    rd_q <= mem_q[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      free_fnd_q <= 1'b0;
      any_q      <= 1'b0;
      valid_q    <= '0;
      ovld_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      free_fnd_q <= free_fnd_d;
      any_q      <= any_d;
      valid_q    <= valid_d;
      if (emit) begin
        ovld_q <= 1'b1;
      end else if (out_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    a_q        <= a_d;
    b_q        <= b_d;
    tag_q      <= tag_d;
    free_idx_q <= free_idx_d;
    cnt_q      <= cnt_d;
    if (emit) begin
      ostat_q <= e_stat;
      opa_q   <= e_pa;
      opb_q   <= e_pb;
      ocnt_q  <= e_cnt;
      ofin_q  <= e_fin;
    end
  end

  assign out_o.valid         = ovld_q;
  assign out_o.status        = ostat_q;
  assign out_o.pair_a        = opa_q;
  assign out_o.pair_b        = opb_q;
  assign out_o.removed_count = ocnt_q;
  assign out_o.final_item    = ofin_q;

  `UPT_ASSERT_IMP(a_wr_free_slot, mem_we, !valid_q[wr_idx], "insert overwrites a used slot")
  `UPT_ASSERT_NXT(a_stall_hold, (state_q == S_SCAN) && !out_free, $stable(idx_q),
                  "scan advanced while result register full")
  `UPT_ASSERT_NXT(a_drain_clear, emit && (e_stat == ST_DRAINED) && e_fin, valid_q == '0,
                  "table not empty after last drained item")
  `UPT_ASSERT_IMP(a_emit_free, emit, out_free, "result overwrites a pending item")

endmodule

`default_nettype wire
